// ===== src/snell_refraction_direction_defines.svh =====
// Assertion macros for the Snell refraction block.
// Used by snell_refraction_direction.sv; clk and rst_n are taken from the including module.
`ifndef SNELL_REFRACTION_DIRECTION_DEFINES_SVH
`define SNELL_REFRACTION_DIRECTION_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define SRD_ASSERT_SAME(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error("assertion failed in snell_refraction_direction");
`define SRD_ASSERT_NEXT(lbl, cond, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error("assertion failed in snell_refraction_direction");
`else
`define SRD_ASSERT_SAME(lbl, cond, prop)
`define SRD_ASSERT_NEXT(lbl, cond, prop)
`endif
`endif

// ===== src/snell_pkg.sv =====
// Widths, stage counts and helpers for the Snell refraction pipeline.
// No dependencies; imported by snell_refraction_direction.
`default_nettype none
package snell_pkg;
  localparam int SQ_STEPS = 27;              // root bits of a 54-bit radicand
  localparam int SQ_RW    = 30;              // remainder width in the root stages
  localparam int NUM_STG  = 6 + SQ_STEPS + 4;
  localparam int CE_W     = 36;
  localparam int WE_W     = 33;
  localparam int K_W      = 37;
  localparam int M_W      = 53;
  localparam int S_W      = 55;

  typedef struct packed {
    logic signed [CE_W-1:0] ce;
    logic signed [WE_W-1:0] we_x;
    logic signed [WE_W-1:0] we_y;
    logic signed [WE_W-1:0] we_z;
    logic signed [15:0]     n_x;
    logic signed [15:0]     n_y;
    logic signed [15:0]     n_z;
    logic                   tir;
  } carry_t;

  function automatic logic [15:0] sat16(input logic signed [S_W-27:0] v);
    logic [15:0] r;
    if (v > 29'sd32767) r = 16'h7fff;
    else if (v < -29'sd32768) r = 16'h8000;
    else r = v[15:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== src/snell_refraction_direction.sv =====
// Throughput: one beat per cycle; the whole pipeline holds while the output beat
// waits, so the 27 one-bit square root stages and the multiplier stages set the depth.
// Reset: synchronous, active low; clears all stage valid bits, payload is not reset.
// Depends on snell_pkg and snell_refraction_direction_defines.svh.
`default_nettype none
`include "snell_refraction_direction_defines.svh"
module snell_refraction_direction import snell_pkg::*; (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // in_x, in_y, in_z, norm_x, norm_y, norm_z, eta_ratio (16 bits each, from bit 0)
  input  wire logic [111:0] in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // out_x, out_y, out_z (16 bits each, from bit 0)
  output logic [47:0]       out_tdata,
  // total_internal
  output logic              out_tuser
);
  logic en;
  logic [NUM_STG:1] vld_r;

  // stage 1
  logic signed [31:0] p_x_r, p_y_r, p_z_r;
  logic [31:0] eta2_1_r;
  logic signed [15:0] w1_r [3];
  logic signed [15:0] n1_r [3];
  logic [15:0] eta1_r;
  // stage 2
  logic signed [18:0] cos2_r;
  logic [31:0] eta2_2_r;
  logic signed [15:0] w2_r [3];
  logic signed [15:0] n2_r [3];
  logic [15:0] eta2f_r;
  // stage 3
  logic [36:0] c2_r;
  logic signed [CE_W-1:0] ce3_r;
  logic [31:0] eta2_3_r;
  logic signed [15:0] w3_r [3];
  logic signed [15:0] n3_r [3];
  logic [15:0] eta3_r;
  // stage 4
  logic [28:0] sin2i_r;
  logic signed [CE_W-1:0] ce4_r;
  logic [31:0] eta2_4_r;
  logic signed [15:0] w4_r [3];
  logic signed [15:0] n4_r [3];
  logic [15:0] eta4_r;
  // stage 5
  logic [60:0] sin2o_r;
  logic signed [CE_W-1:0] ce5_r;
  logic signed [WE_W-1:0] we5_r [3];
  logic signed [15:0] n5_r [3];
  // stage 6 and the root stages
  logic [53:0]       sq_rad_r  [SQ_STEPS+1];
  logic [SQ_RW-1:0]  sq_rem_r  [SQ_STEPS+1];
  logic [SQ_STEPS-1:0] sq_root_r [SQ_STEPS+1];
  carry_t            cr_r      [SQ_STEPS+1];
  // tail
  logic signed [K_W-1:0] k_r;
  carry_t cr_k_r;
  logic signed [M_W-1:0] m_r [3];
  logic signed [WE_W-1:0] we_m_r [3];
  logic tir_m_r;
  logic signed [S_W-1:0] s_r [3];
  logic tir_s_r;
  logic [47:0] out_data_r;
  logic out_tir_r;

  logic signed [15:0] w_in [3];
  logic signed [15:0] n_in [3];
  logic [15:0] eta_in;
  logic signed [32:0] dot_rnd;
  logic signed [36:0] c2_full;

  assign en = !vld_r[NUM_STG] || out_tready;
  assign in_tready = en;
  assign out_tvalid = vld_r[NUM_STG];
  assign out_tdata = out_data_r;
  assign out_tuser = out_tir_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      w_in[i] = signed'(in_tdata[16*i +: 16]);
      n_in[i] = signed'(in_tdata[48 + 16*i +: 16]);
    end
    eta_in = in_tdata[111:96];
    dot_rnd = 33'(p_x_r) + 33'(p_y_r) + 33'(p_z_r) + 33'sd8192;
    // The square of a 19-bit cosine needs 37 bits before it is registered.
    c2_full = cos2_r * cos2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NUM_STG-1:1], in_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_x_r <= w_in[0] * n_in[0];
      p_y_r <= w_in[1] * n_in[1];
      p_z_r <= w_in[2] * n_in[2];
      eta2_1_r <= eta_in * eta_in;
      w1_r <= w_in;
      n1_r <= n_in;
      eta1_r <= eta_in;

      cos2_r <= dot_rnd[32:14];
      eta2_2_r <= eta2_1_r;
      w2_r <= w1_r;
      n2_r <= n1_r;
      eta2f_r <= eta1_r;

      c2_r <= unsigned'(c2_full);
      ce3_r <= cos2_r * signed'({1'b0, eta2f_r});
      eta2_3_r <= eta2_2_r;
      w3_r <= w2_r;
      n3_r <= n2_r;
      eta3_r <= eta2f_r;

      sin2i_r <= (c2_r >= 37'(1) << 28) ? '0 : 29'((37'(1) << 28) - c2_r);
      ce4_r <= ce3_r;
      eta2_4_r <= eta2_3_r;
      w4_r <= w3_r;
      n4_r <= n3_r;
      eta4_r <= eta3_r;

      sin2o_r <= 61'(sin2i_r) * 61'(eta2_4_r);
      ce5_r <= ce4_r;
      for (int i = 0; i < 3; i++) begin
        we5_r[i] <= w4_r[i] * signed'({1'b0, eta4_r});
      end
      n5_r <= n4_r;

      // A radicand of zero on internal reflection keeps the root stages quiet.
      cr_r[0].tir  <= sin2o_r >= (61'(1) << 52);
      sq_rad_r[0]  <= (sin2o_r >= (61'(1) << 52)) ? '0 : 54'((61'(1) << 52) - sin2o_r);
      sq_rem_r[0]  <= '0;
      sq_root_r[0] <= '0;
      cr_r[0].ce   <= ce5_r;
      cr_r[0].we_x <= we5_r[0];
      cr_r[0].we_y <= we5_r[1];
      cr_r[0].we_z <= we5_r[2];
      cr_r[0].n_x  <= n5_r[0];
      cr_r[0].n_y  <= n5_r[1];
      cr_r[0].n_z  <= n5_r[2];
    end
  end

  // Restoring square root, one result bit per stage from the top radicand pair down.
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    logic [SQ_RW-1:0] rem_sh, trial;
    assign rem_sh = {sq_rem_r[j][SQ_RW-3:0], sq_rad_r[j][53:52]};
    assign trial  = {1'b0, sq_root_r[j], 2'b01};
    always_ff @(posedge clk) begin
      if (en) begin
        sq_rad_r[j+1] <= {sq_rad_r[j][51:0], 2'b00};
        cr_r[j+1] <= cr_r[j];
        if (rem_sh >= trial) begin
          sq_rem_r[j+1]  <= rem_sh - trial;
          sq_root_r[j+1] <= {sq_root_r[j][SQ_STEPS-2:0], 1'b1};
        end else begin
          sq_rem_r[j+1]  <= rem_sh;
          sq_root_r[j+1] <= {sq_root_r[j][SQ_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k_r <= K_W'(cr_r[SQ_STEPS].ce) - signed'(K_W'(sq_root_r[SQ_STEPS]));
      cr_k_r <= cr_r[SQ_STEPS];

      m_r[0] <= k_r * cr_k_r.n_x;
      m_r[1] <= k_r * cr_k_r.n_y;
      m_r[2] <= k_r * cr_k_r.n_z;
      we_m_r[0] <= cr_k_r.we_x;
      we_m_r[1] <= cr_k_r.we_y;
      we_m_r[2] <= cr_k_r.we_z;
      tir_m_r <= cr_k_r.tir;

      for (int i = 0; i < 3; i++) begin
        s_r[i] <= S_W'(m_r[i]) - (S_W'(we_m_r[i]) <<< 14) + (S_W'(1) <<< 25);
      end
      tir_s_r <= tir_m_r;

      for (int i = 0; i < 3; i++) begin
        out_data_r[16*i +: 16] <= tir_s_r ? 16'h0000 : sat16(s_r[i][S_W-1:26]);
      end
      out_tir_r <= tir_s_r;
    end
  end

  `SRD_ASSERT_SAME(a_tir_zero, out_tvalid && out_tuser, out_tdata == 48'h0)
  `SRD_ASSERT_NEXT(a_enter, in_tvalid && in_tready, vld_r[1])
  `SRD_ASSERT_SAME(a_root_range, vld_r[6 + SQ_STEPS], sq_root_r[SQ_STEPS] <= (SQ_STEPS'(1) << 26))
endmodule
`default_nettype wire
